// File: sv/tsbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbc_pkg
// Shared types and constants of the turn signal blinker control block.
// ----------------------------------------------------------------------------
package tsbc_pkg;

    // lamp action codes reported with each result word
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_HAZARD  = 3'd1;
    localparam logic [2:0] ACT_CLEAR   = 3'd2;
    localparam logic [2:0] ACT_LEFT    = 3'd3;
    localparam logic [2:0] ACT_RIGHT   = 3'd4;
    localparam logic [2:0] ACT_ANIMATE = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_BLINK_PERIOD   = 2'd0;
    localparam logic [1:0] REG_TILT_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_YAW_OFFSET     = 2'd2;

    // register reset values
    localparam logic [7:0]         RST_BLINK_PERIOD   = 8'd5;
    localparam logic [15:0]        RST_TILT_THRESHOLD = 16'd3000;
    localparam logic signed [15:0] RST_YAW_OFFSET     = 16'sd6600;

    // floor(b / 5) = (b * RECIP5) >> RECIP5_SHIFT, exact for b below 2^18
    localparam logic [16:0] RECIP5       = 17'd104858;
    localparam int          RECIP5_SHIFT = 19;

    // stream word widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // one sensor tick as received
    typedef struct packed {
        logic               left_button;
        logic               right_button;
        logic               hazard_button;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_z;
    } t_sample;

    // one sensor tick after the yaw arithmetic
    typedef struct packed {
        logic               left_button;
        logic               right_button;
        logic               hazard_button;
        logic signed [15:0] yaw;
    } t_tick;

endpackage

// File: sv/tsbc_yaw_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbc_yaw_pipe
// Three-stage pipeline forming the rotated yaw from the gyro samples:
// yaw = wrap16(trunc(-0.95 * gx) + trunc(0.3 * gz) - offset).
// ----------------------------------------------------------------------------
module tsbc_yaw_pipe
    import tsbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [15:0] i_yaw_offset,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_sample            i_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output t_tick              o_tick
);

    // stage 1: input register
    logic    r_v1;
    t_sample r_s1;
    // stage 2: scaled magnitudes ready for the divide by five
    logic        r_v2;
    logic [17:0] r_b1;
    logic [15:0] r_b2;
    logic        r_neg1, r_neg2;
    logic [2:0]  r_btn2;
    // stage 3: quotient magnitudes
    logic        r_v3;
    logic [14:0] r_q1;
    logic [13:0] r_q2;
    logic        r_neg1_3, r_neg2_3;
    logic [2:0]  r_btn3;

    logic        rdy2, rdy3;
    logic [16:0] abs_x, abs_z;
    logic [19:0] scl_x;
    logic [16:0] scl_z;
    logic [34:0] prod1;
    logic [32:0] prod2;
    logic signed [16:0] term1, term2, sum;
    logic [15:0] yaw_raw;

    // per-stage ready chain
    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = !r_v1 || rdy2;

    // magnitudes scaled by 19 and 3, then the power-of-two part of 20 and 10
    always_comb begin
        abs_x = r_s1.gyro_x[15] ? 17'(-{r_s1.gyro_x[15], r_s1.gyro_x})
                                : {1'b0, r_s1.gyro_x};
        abs_z = r_s1.gyro_z[15] ? 17'(-{r_s1.gyro_z[15], r_s1.gyro_z})
                                : {1'b0, r_s1.gyro_z};
        scl_x = 20'(abs_x) * 20'd19;
        scl_z = abs_z * 17'd3;
    end

    // divide by five through the reciprocal
    assign prod1 = 35'(r_b1) * 35'(RECIP5);
    assign prod2 = 33'(r_b2) * 33'(RECIP5);

    // signs back on, sum, offset removal with 16-bit wrap
    always_comb begin
        term1   = r_neg1_3 ? -$signed({2'b00, r_q1}) : $signed({2'b00, r_q1});
        term2   = r_neg2_3 ? -$signed({3'b000, r_q2}) : $signed({3'b000, r_q2});
        sum     = term1 + term2;
        yaw_raw = sum[15:0] - i_yaw_offset;
    end

    assign o_valid             = r_v3;
    assign o_tick.left_button   = r_btn3[0];
    assign o_tick.right_button  = r_btn3[1];
    assign o_tick.hazard_button = r_btn3[2];
    assign o_tick.yaw           = $signed(yaw_raw);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_ready) r_v1 <= i_valid;
            if (rdy2)    r_v2 <= r_v1;
            if (rdy3)    r_v3 <= r_v2;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_s1 <= i_sample;
        if (rdy2 && r_v1) begin
            r_b1   <= scl_x[19:2];
            r_b2   <= scl_z[16:1];
            r_neg1 <= !r_s1.gyro_x[15] && (r_s1.gyro_x != 16'sd0);
            r_neg2 <= r_s1.gyro_z[15];
            r_btn2 <= {r_s1.hazard_button, r_s1.right_button, r_s1.left_button};
        end
        if (rdy3 && r_v2) begin
            r_q1     <= prod1[RECIP5_SHIFT +: 15];
            r_q2     <= prod2[RECIP5_SHIFT +: 14];
            r_neg1_3 <= r_neg1;
            r_neg2_3 <= r_neg2;
            r_btn3   <= r_btn2;
        end
    end

endmodule

// File: sv/turn_signal_blinker_control_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turn_signal_blinker_control_top
// Turn signal, hazard and tilt-cancel control driven by sensor ticks.
// ----------------------------------------------------------------------------
// Usage:
//   slave stream takes one sensor tick per word: three button levels and
//   the gyro X and Z samples. master stream returns one result word per
//   tick: lamp action, cancel flag, yaw, lamp states and tilt flag.
//   config channel writes blink period, tilt threshold and yaw offset by
//   index; it is always ready, unknown indexes are dropped. write it only
//   while no tick is in flight.
// Pipeline and throughput:
//   three yaw stages (input register, scaling, reciprocal multiply) feed
//   the lamp state logic and the result register; one word per cycle
//   sustained while the master stream takes words. the lamp state updates
//   in the cycle the result register is loaded.
// Reset:
//   synchronous active-low; clears all lamp, selection and tilt state, the
//   tick counter and the pipeline, and loads register defaults.
// Stall:
//   a held result word stays in the output register; each stage keeps
//   taking words until it is full, then back-pressure reaches the slave.
// ----------------------------------------------------------------------------
module turn_signal_blinker_control_top
    import tsbc_pkg::*;
#(
    parameter int COUNTER_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [0] left_button, [1] right_button, [2] hazard_button,
    // [18:3] gyro_x, [34:19] gyro_z, [39:35] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [2:0] lamp_action, [3] cancel_clear, [19:4] yaw, [20] left_lit,
    // [21] right_lit, [22] hazard_lit, [23] tilted
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    localparam int CW = (COUNTER_BITS > 8) ? COUNTER_BITS : 8;

    // config registers
    logic [7:0]         r_blink_period;
    logic [15:0]        r_tilt_threshold;
    logic signed [15:0] r_yaw_offset;

    // control state
    logic r_left_press_seen, r_right_press_seen;
    logic r_left_selected, r_right_selected;
    logic r_left_on, r_right_on, r_hazard_on, r_tilt_hold;
    logic [COUNTER_BITS-1:0] r_tick_count;
    logic r_out_valid;
    logic [OUT_DATA_W-1:0] r_out;

    logic n_left_press_seen, n_right_press_seen;
    logic n_left_selected, n_right_selected;
    logic n_left_on, n_right_on, n_hazard_on, n_tilt_hold;
    logic [COUNTER_BITS-1:0] n_tick_count;
    logic [OUT_DATA_W-1:0] n_out;

    t_sample in_sample;
    t_tick   tick;
    logic    tick_valid, out_ready;

    logic [COUNTER_BITS-1:0] cnt_inc;
    logic                    cnt_hit;
    logic [16:0]             mag;
    logic                    over;
    logic                    counting;
    logic [2:0]              action;
    logic                    cancel;

    assign o_cfg_ready = 1'b1;

    // unpack the slave word
    assign in_sample.left_button   = i_s_axis_tdata[0];
    assign in_sample.right_button  = i_s_axis_tdata[1];
    assign in_sample.hazard_button = i_s_axis_tdata[2];
    assign in_sample.gyro_x        = $signed(i_s_axis_tdata[18:3]);
    assign in_sample.gyro_z        = $signed(i_s_axis_tdata[34:19]);

    tsbc_yaw_pipe u_yaw (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_yaw_offset (r_yaw_offset),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_sample     (in_sample),
        .o_valid      (tick_valid),
        .i_ready      (out_ready),
        .o_tick       (tick)
    );

    assign out_ready = !r_out_valid || i_m_axis_tready;

    // blink counter step
    assign cnt_inc = r_tick_count + 1'b1;
    assign cnt_hit = CW'(cnt_inc) >= CW'(r_blink_period);

    // yaw magnitude and tilt compare
    assign mag  = tick.yaw[15] ? 17'(-{tick.yaw[15], tick.yaw}) : {1'b0, tick.yaw};
    assign over = mag > 17'(r_tilt_threshold);

    // button edges, priority chain and upright cancel
    always_comb begin
        n_left_press_seen  = r_left_press_seen;
        n_right_press_seen = r_right_press_seen;
        n_left_selected    = r_left_selected;
        n_right_selected   = r_right_selected;
        n_left_on          = r_left_on;
        n_right_on         = r_right_on;
        n_hazard_on        = r_hazard_on;
        n_tilt_hold        = r_tilt_hold;
        n_tick_count       = r_tick_count;
        action             = ACT_NONE;
        cancel             = 1'b0;

        // left button toggles on release
        if (tick.left_button) begin
            n_left_press_seen = 1'b1;
        end else if (r_left_press_seen) begin
            if (n_left_selected) begin
                n_left_selected = 1'b0;
            end else begin
                n_left_selected  = 1'b1;
                n_right_selected = 1'b0;
            end
            n_left_press_seen = 1'b0;
        end

        // right button toggles on release
        if (tick.right_button) begin
            n_right_press_seen = 1'b1;
        end else if (r_right_press_seen) begin
            if (n_right_selected) begin
                n_right_selected = 1'b0;
            end else begin
                n_right_selected = 1'b1;
                n_left_selected  = 1'b0;
            end
            n_right_press_seen = 1'b0;
        end

        if (tick.hazard_button) begin
            n_left_selected  = 1'b0;
            n_right_selected = 1'b0;
        end

        if (over) n_tilt_hold = 1'b1;

        // counter runs on every branch but the immediate drops
        counting = tick.hazard_button || n_left_selected || n_right_selected ||
                   !(r_left_on || r_right_on || r_hazard_on);
        if (counting) n_tick_count = cnt_hit ? '0 : cnt_inc;

        if (tick.hazard_button) begin
            if (cnt_hit) begin
                action      = r_hazard_on ? ACT_CLEAR : ACT_HAZARD;
                n_hazard_on = !r_hazard_on;
            end
        end else if (n_left_selected) begin
            if (cnt_hit) begin
                action    = r_left_on ? ACT_CLEAR : ACT_LEFT;
                n_left_on = !r_left_on;
            end
        end else if (n_right_selected) begin
            if (cnt_hit) begin
                action     = r_right_on ? ACT_CLEAR : ACT_RIGHT;
                n_right_on = !r_right_on;
            end
        end else if (r_left_on) begin
            action    = ACT_CLEAR;
            n_left_on = 1'b0;
        end else if (r_right_on) begin
            action     = ACT_CLEAR;
            n_right_on = 1'b0;
        end else if (r_hazard_on) begin
            action      = ACT_CLEAR;
            n_hazard_on = 1'b0;
        end else if (cnt_hit) begin
            action = ACT_ANIMATE;
        end

        // return to upright cancels the blinkers
        if (!over && n_tilt_hold) begin
            if (n_left_selected || n_right_selected) begin
                cancel           = 1'b1;
                n_left_selected  = 1'b0;
                n_right_selected = 1'b0;
                n_left_on        = 1'b0;
                n_right_on       = 1'b0;
            end
            n_tilt_hold = 1'b0;
        end

        n_out = {n_tilt_hold, n_hazard_on, n_right_on, n_left_on,
                 tick.yaw, cancel, action};
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_period   <= RST_BLINK_PERIOD;
            r_tilt_threshold <= RST_TILT_THRESHOLD;
            r_yaw_offset     <= RST_YAW_OFFSET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_BLINK_PERIOD:   r_blink_period   <= i_cfg_data[7:0];
                REG_TILT_THRESHOLD: r_tilt_threshold <= i_cfg_data;
                REG_YAW_OFFSET:     r_yaw_offset     <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // control state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_press_seen  <= 1'b0;
            r_right_press_seen <= 1'b0;
            r_left_selected    <= 1'b0;
            r_right_selected   <= 1'b0;
            r_left_on          <= 1'b0;
            r_right_on         <= 1'b0;
            r_hazard_on        <= 1'b0;
            r_tilt_hold        <= 1'b0;
            r_tick_count       <= '0;
            r_out_valid        <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= tick_valid;
            if (tick_valid) begin
                r_left_press_seen  <= n_left_press_seen;
                r_right_press_seen <= n_right_press_seen;
                r_left_selected    <= n_left_selected;
                r_right_selected   <= n_right_selected;
                r_left_on          <= n_left_on;
                r_right_on         <= n_right_on;
                r_hazard_on        <= n_hazard_on;
                r_tilt_hold        <= n_tilt_hold;
                r_tick_count       <= n_tick_count;
            end
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (out_ready && tick_valid) r_out <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // a hazard-on action leaves the hazard lamp lit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[2:0] == ACT_HAZARD) |-> o_m_axis_tdata[22])
        else $error("hazard action without hazard lamp");

    // an upright cancel leaves both arrows dark and the tilt flag clear
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[3]) |->
        (!o_m_axis_tdata[20] && !o_m_axis_tdata[21] && !o_m_axis_tdata[23]))
        else $error("cancel left a lamp or tilt flag set");

    // left and right selections exclude each other
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_left_selected && r_right_selected))
        else $error("left and right both selected");

endmodule

// File: dv/tb_turn_signal_blinker_control_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_turn_signal_blinker_control_top
// Self-checking bench for the turn signal blinker control block.
// ----------------------------------------------------------------------------
// A short table of sensor ticks runs first: idle animation after reset,
// gyro extremes, the most negative yaw, left and right select and
// deselect, hazard hold and release, and a cancel on return to upright.
// Seven phases of random ticks follow, each with its own register setting
// and one of four idle and stall patterns. Button levels mostly form press
// and release sequences, and the gyro is mostly steered around the upright
// yaw so the tilt and cancel logic stays busy. Every result word is checked
// field by field against a fixed table result or the bench lamp predictor.
// ----------------------------------------------------------------------------
module tb_turn_signal_blinker_control_top;
    import tsbc_pkg::*;

    localparam int CNT_W        = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_TICKS  = 75;
    localparam int DIR_ROWS     = 25;
    localparam logic [1:0] REG_SPARE = 2'd3;

    // result word, laid out as on the master stream
    typedef struct packed {
        logic               tilted;
        logic               hazard_lit;
        logic               right_lit;
        logic               left_lit;
        logic signed [15:0] yaw;
        logic               cancel_clear;
        logic [2:0]         lamp_action;
    } t_lamp_result;

    // one row of the directed table
    typedef struct packed {
        t_sample      tick;
        logic         has_want;
        t_lamp_result want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [1:0]            i_cfg_index;
    logic [15:0]           i_cfg_data;

    // predictor copy of registers and lamp state
    logic [7:0]         blink_per;
    logic [15:0]        tilt_thr;
    logic signed [15:0] yaw_off;
    logic               left_held, right_held, left_sel, right_sel;
    logic               left_lamp, right_lamp, hazard_lamp, tilt_hold;
    logic [CNT_W-1:0]   tick_cnt;

    t_lamp_result lamp_expect_q[$];

    int          errors       = 0;
    int          results_seen = 0;
    int          ticks_sent   = 0;
    int          reg_writes   = 0;
    int          settings_run = 0;
    int          cancels_seen = 0;
    int          action_seen[6];
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;
    bit          hold_req     = 1'b0;
    int unsigned cycle_count  = 0;

    turn_signal_blinker_control_top #(
        .COUNTER_BITS(CNT_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run length guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d words still expected",
                 cycle_count, lamp_expect_q.size());
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on result %0d, %s: got %0d expected %0d",
                 results_seen, what, got, want);
        errors++;
    endtask

    // one blink counter step, true when the period is reached
    function automatic bit period_reached();
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= blink_per) begin
            tick_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // lamp state update for one sensor tick
    function automatic t_lamp_result blink_step(input t_sample s);
        t_lamp_result       r;
        int                 raw_sum;
        logic signed [15:0] sum16;
        int                 mag;

        r = '0;
        r.lamp_action = ACT_NONE;

        // selection toggles on button release
        if (s.left_button) begin
            left_held = 1'b1;
        end else if (left_held) begin
            if (left_sel) begin
                left_sel = 1'b0;
            end else begin
                left_sel  = 1'b1;
                right_sel = 1'b0;
            end
            left_held = 1'b0;
        end
        if (s.right_button) begin
            right_held = 1'b1;
        end else if (right_held) begin
            if (right_sel) begin
                right_sel = 1'b0;
            end else begin
                right_sel = 1'b1;
                left_sel  = 1'b0;
            end
            right_held = 1'b0;
        end
        if (s.hazard_button) begin
            left_sel  = 1'b0;
            right_sel = 1'b0;
        end

        // yaw with truncating divisions, wrapped to 16 bits twice
        raw_sum = (int'(s.gyro_x) * -95) / 100 + (int'(s.gyro_z) * 3) / 10;
        sum16   = raw_sum[15:0];
        r.yaw   = sum16 - yaw_off;
        mag     = (r.yaw < 0) ? -int'(r.yaw) : int'(r.yaw);
        if (mag > int'(tilt_thr)) tilt_hold = 1'b1;

        // priority chain
        if (s.hazard_button) begin
            if (period_reached()) begin
                r.lamp_action = hazard_lamp ? ACT_CLEAR : ACT_HAZARD;
                hazard_lamp   = ~hazard_lamp;
            end
        end else if (left_sel) begin
            if (period_reached()) begin
                r.lamp_action = left_lamp ? ACT_CLEAR : ACT_LEFT;
                left_lamp     = ~left_lamp;
            end
        end else if (right_sel) begin
            if (period_reached()) begin
                r.lamp_action = right_lamp ? ACT_CLEAR : ACT_RIGHT;
                right_lamp    = ~right_lamp;
            end
        end else if (left_lamp) begin
            r.lamp_action = ACT_CLEAR;
            left_lamp     = 1'b0;
        end else if (right_lamp) begin
            r.lamp_action = ACT_CLEAR;
            right_lamp    = 1'b0;
        end else if (hazard_lamp) begin
            r.lamp_action = ACT_CLEAR;
            hazard_lamp   = 1'b0;
        end else if (period_reached()) begin
            r.lamp_action = ACT_ANIMATE;
        end

        // back upright cancels the blinkers
        if (mag <= int'(tilt_thr) && tilt_hold) begin
            if (left_sel || right_sel) begin
                r.cancel_clear = 1'b1;
                left_sel       = 1'b0;
                right_sel      = 1'b0;
                left_lamp      = 1'b0;
                right_lamp     = 1'b0;
            end
            tilt_hold = 1'b0;
        end

        r.left_lit   = left_lamp;
        r.right_lit  = right_lamp;
        r.hazard_lit = hazard_lamp;
        r.tilted     = tilt_hold;
        return r;
    endfunction

    function automatic t_sample tk(input logic lb, input logic rb, input logic hb,
                                   input int gx, input int gz);
        t_sample s;
        s.left_button   = lb;
        s.right_button  = rb;
        s.hazard_button = hb;
        s.gyro_x        = gx[15:0];
        s.gyro_z        = gz[15:0];
        return s;
    endfunction

    // idle tick straight after reset: counting only, tilted by the default offset
    function automatic t_lamp_result idle_result(input logic [2:0] act);
        t_lamp_result r;
        r             = '0;
        r.lamp_action = act;
        r.yaw         = -16'sd6600;
        r.tilted      = 1'b1;
        return r;
    endfunction

    // offer one word, called and returning at a falling edge; tvalid stays up
    task automatic send_tick(input t_sample s, input logic has_want,
                             input t_lamp_result fixed);
        t_lamp_result pred;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'b0, s.gyro_z, s.gyro_x,
                            s.hazard_button, s.right_button, s.left_button};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = blink_step(s);
        lamp_expect_q.push_back(has_want ? fixed : pred);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // wait for the pipe to drain, then write the registers
    task automatic load_settings(input logic [7:0] per, input logic [15:0] thr,
                                 input logic signed [15:0] off, input bit poke_spare);
        logic [1:0]  idx[4];
        logic [15:0] val[4];
        int          n;
        while (lamp_expect_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        idx[0] = REG_BLINK_PERIOD;   val[0] = {8'($urandom_range(255)), per};
        idx[1] = REG_TILT_THRESHOLD; val[1] = thr;
        idx[2] = REG_YAW_OFFSET;     val[2] = off;
        idx[3] = REG_SPARE;          val[3] = 16'($urandom);
        n = poke_spare ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                REG_BLINK_PERIOD:   blink_per = val[k][7:0];
                REG_TILT_THRESHOLD: tilt_thr  = val[k];
                REG_YAW_OFFSET:     yaw_off   = val[k];
                default: ;
            endcase
            reg_writes++;
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // result receiver with random stalls and one long hold-off on request
    initial begin : result_sink
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_lamp_result got;
        t_lamp_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_lamp_result'(o_m_axis_tdata);
            if (lamp_expect_q.size() == 0) begin
                report_mismatch("word with none expected", int'(o_m_axis_tdata), 0);
            end else begin
                want = lamp_expect_q.pop_front();
                if (got.lamp_action !== want.lamp_action)
                    report_mismatch("lamp_action", got.lamp_action, want.lamp_action);
                if (got.cancel_clear !== want.cancel_clear)
                    report_mismatch("cancel_clear", got.cancel_clear, want.cancel_clear);
                if (got.yaw !== want.yaw)
                    report_mismatch("yaw", int'(got.yaw), int'(want.yaw));
                if (got.left_lit !== want.left_lit)
                    report_mismatch("left_lit", got.left_lit, want.left_lit);
                if (got.right_lit !== want.right_lit)
                    report_mismatch("right_lit", got.right_lit, want.right_lit);
                if (got.hazard_lit !== want.hazard_lit)
                    report_mismatch("hazard_lit", got.hazard_lit, want.hazard_lit);
                if (got.tilted !== want.tilted)
                    report_mismatch("tilted", got.tilted, want.tilted);
                if (want.lamp_action <= ACT_ANIMATE) action_seen[want.lamp_action]++;
                if (want.cancel_clear) cancels_seen++;
            end
            results_seen++;
        end
    end

    // stimulus
    initial begin : stimulus
        t_dir_row    dir_rows[DIR_ROWS];
        t_sample     s;
        logic        lb_lvl, rb_lvl, hb_lvl;
        int          span, target, gz_v, gx_v;
        logic signed [15:0] rem16;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = REG_BLINK_PERIOD;
        i_cfg_data      = '0;
        for (int k = 0; k < 6; k++) action_seen[k] = 0;

        // predictor reset state
        blink_per   = RST_BLINK_PERIOD;
        tilt_thr    = RST_TILT_THRESHOLD;
        yaw_off     = RST_YAW_OFFSET;
        left_held   = 1'b0;
        right_held  = 1'b0;
        left_sel    = 1'b0;
        right_sel   = 1'b0;
        left_lamp   = 1'b0;
        right_lamp  = 1'b0;
        hazard_lamp = 1'b0;
        tilt_hold   = 1'b0;
        tick_cnt    = '0;

        // directed table; gyro_z of 22000 cancels the default offset (upright)
        dir_rows[0]  = {tk(0, 0, 0, 0, 0), 1'b1, idle_result(ACT_NONE)};
        dir_rows[1]  = {tk(0, 0, 0, 0, 0), 1'b1, idle_result(ACT_NONE)};
        dir_rows[2]  = {tk(0, 0, 0, 0, 0), 1'b1, idle_result(ACT_NONE)};
        dir_rows[3]  = {tk(0, 0, 0, 0, 0), 1'b1, idle_result(ACT_NONE)};
        dir_rows[4]  = {tk(0, 0, 0, 0, 0), 1'b1, idle_result(ACT_ANIMATE)};
        dir_rows[5]  = {tk(0, 0, 0, -32768, 32767), 1'b0, t_lamp_result'('0)};
        dir_rows[6]  = {tk(0, 0, 0, 32767, -32768), 1'b0, t_lamp_result'('0)};
        // most negative yaw
        dir_rows[7]  = {tk(0, 0, 0, 27546, 0), 1'b0, t_lamp_result'('0)};
        // left select, then count toward a left toggle
        dir_rows[8]  = {tk(1, 0, 0, 0, 22000), 1'b0, t_lamp_result'('0)};
        dir_rows[9]  = {tk(0, 0, 0, 0, 22000), 1'b0, t_lamp_result'('0)};
        dir_rows[10] = {tk(0, 0, 0, 0, 22000), 1'b0, t_lamp_result'('0)};
        dir_rows[11] = {tk(0, 0, 0, 0, 22000), 1'b0, t_lamp_result'('0)};
        dir_rows[12] = {tk(0, 0, 0, 0, 22000), 1'b0, t_lamp_result'('0)};
        dir_rows[13] = {tk(0, 0, 0, 0, 22000), 1'b0, t_lamp_result'('0)};
        // right select takes over, right deselect drops the lamp
        dir_rows[14] = {tk(0, 1, 0, 0, 22000), 1'b0, t_lamp_result'('0)};
        dir_rows[15] = {tk(0, 0, 0, 0, 22000), 1'b0, t_lamp_result'('0)};
        dir_rows[16] = {tk(0, 1, 0, 0, 22000), 1'b0, t_lamp_result'('0)};
        dir_rows[17] = {tk(0, 0, 0, 0, 22000), 1'b0, t_lamp_result'('0)};
        // hazard hold and release
        dir_rows[18] = {tk(0, 0, 1, 0, 22000), 1'b0, t_lamp_result'('0)};
        dir_rows[19] = {tk(0, 0, 1, 0, 22000), 1'b0, t_lamp_result'('0)};
        dir_rows[20] = {tk(1, 1, 1, 0, 22000), 1'b0, t_lamp_result'('0)};
        dir_rows[21] = {tk(0, 0, 0, 0, 22000), 1'b0, t_lamp_result'('0)};
        // select while tilted, then cancel on the upright tick
        dir_rows[22] = {tk(1, 0, 0, 0, 0), 1'b0, t_lamp_result'('0)};
        dir_rows[23] = {tk(0, 0, 0, 0, 0), 1'b0, t_lamp_result'('0)};
        dir_rows[24] = {tk(0, 0, 0, 0, 22000), 1'b0, t_lamp_result'('0)};

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_tick(dir_rows[r].tick, dir_rows[r].has_want, dir_rows[r].want);
        end
        i_s_axis_tvalid <= 1'b0;

        lb_lvl = 1'b0;
        rb_lvl = 1'b0;
        hb_lvl = 1'b0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: load_settings(8'd1, 16'd0, -16'sd32768, 1'b0);
                1: load_settings(8'd255, 16'd65535, 16'sd32767, 1'b0);
                2: load_settings(8'd0, 16'd32768, 16'sd0, 1'b1);
                3: load_settings(8'd2, 16'd1500, 16'sd6600, 1'b0);
                4: load_settings(8'd3, 16'($urandom_range(8000)), 16'($urandom), 1'b0);
                5: load_settings(8'd4, 16'd3000, -16'sd6600, 1'b0);
                default: load_settings(8'($urandom_range(6, 1)), 16'($urandom_range(9000)),
                                       16'($urandom), 1'b0);
            endcase
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
                default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            // long receiver hold-off while words keep coming
            if (ph == 4) hold_req = 1'b1;

            for (int n = 0; n < PHASE_TICKS; n++) begin
                if ($urandom_range(99) < 10) begin
                    // noise word
                    s = tk($urandom_range(1), $urandom_range(1), $urandom_range(1),
                           int'($urandom), int'($urandom));
                end else begin
                    // press and release sequences
                    if ($urandom_range(99) < 30) lb_lvl = ~lb_lvl;
                    if ($urandom_range(99) < 30) rb_lvl = ~rb_lvl;
                    if ($urandom_range(99) < (hb_lvl ? 20 : 5)) hb_lvl = ~hb_lvl;
                    if ($urandom_range(99) < 25) begin
                        s = tk(lb_lvl, rb_lvl, hb_lvl, int'($urandom), int'($urandom));
                    end else begin
                        // steer the yaw around zero, scaled to the threshold
                        span   = (tilt_thr > 16'd12000) ? 24000 : int'(tilt_thr) * 2 + 64;
                        target = int'(yaw_off) + int'($urandom_range(2 * span)) - span;
                        gz_v   = int'($urandom_range(4000)) - 2000;
                        rem16  = 16'(target - (gz_v * 3) / 10);
                        gx_v   = -(int'(rem16) * 100) / 95;
                        if (gx_v > 32767) gx_v = 32767;
                        if (gx_v < -32768) gx_v = -32768;
                        s = tk(lb_lvl, rb_lvl, hb_lvl, gx_v, gz_v);
                    end
                end
                send_tick(s, 1'b0, t_lamp_result'('0));
            end
            i_s_axis_tvalid <= 1'b0;
        end

        // drain
        while (lamp_expect_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("covered %0d ticks over %0d register settings (%0d writes), %0d results",
                 ticks_sent, settings_run, reg_writes, results_seen);
        $display("actions none/hazard/clear/left/right/anim %0d/%0d/%0d/%0d/%0d/%0d, %0d cancels",
                 action_seen[0], action_seen[1], action_seen[2], action_seen[3],
                 action_seen[4], action_seen[5], cancels_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
